@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the pruner checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising clk edge, off while arst_n is low.
`define CWP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define CWP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);
`endif

@@ rtl/core/cwp_pkg.sv @@
// Types, constants and request codes shared by the waypoint pruner.
`default_nettype none
package cwp_pkg;
	localparam int COORD_BITS = 24;
	localparam int MIN_SEG_W = 16;
	localparam int COS_W = 15;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_SEG_LEN_SQ = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COS_THRESHOLD = CFG_IDX_W'(1);

	localparam logic [MIN_SEG_W-1:0] MIN_SEG_RESET = MIN_SEG_W'(6);
	localparam logic [COS_W-1:0] COS_RESET = COS_W'(32440);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] point_z;
		logic is_final;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic signed [COORD_BITS-1:0] out_z;
		logic out_final;
	} out_item_t;

	// FIRST: start of path, EMIT: final after anchor only,
	// PEND: second point, TEST: decide pending against the new point
	typedef enum logic [1:0] {
		CMD_FIRST,
		CMD_EMIT,
		CMD_PEND,
		CMD_TEST
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		point_t pt;
		logic fin;
	} cmd_t;
endpackage
`default_nettype wire

@@ rtl/core/cwp_front.sv @@
// Front end: takes waypoint requests and classifies them by position in the path.
`default_nettype none
module cwp_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input cwp_pkg::in_item_t in_data,
	input logic q_full,
	output logic push,
	output cwp_pkg::cmd_t push_cmd
);
	import cwp_pkg::*;

	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE = 2'd1;
	localparam logic [1:0] SEEN_TWO = 2'd2;

	logic [1:0] seen_q;
	logic [1:0] seen_d;
	cmd_op_t op;

	assign in_stall = q_full;
	assign push = in_valid & ~q_full;

	always_comb begin
		seen_d = seen_q;
		op = CMD_FIRST;
		unique case (seen_q)
			SEEN_ONE: begin
				op = in_data.is_final ? CMD_EMIT : CMD_PEND;
				seen_d = in_data.is_final ? SEEN_NONE : SEEN_TWO;
			end
			SEEN_TWO: begin
				op = CMD_TEST;
				seen_d = in_data.is_final ? SEEN_NONE : SEEN_TWO;
			end
			default: begin
				// unused code behaves as start of path
				op = CMD_FIRST;
				seen_d = in_data.is_final ? SEEN_NONE : SEEN_ONE;
			end
		endcase
	end

	always_comb begin
		push_cmd.op = op;
		push_cmd.pt.x = in_data.point_x;
		push_cmd.pt.y = in_data.point_y;
		push_cmd.pt.z = in_data.point_z;
		push_cmd.fin = in_data.is_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= SEEN_NONE;
		end else if (push) begin
			seen_q <= seen_d;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/cwp_queue.sv @@
// Short request queue between the front end and the back end.
`default_nettype none
module cwp_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cwp_pkg::cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic empty,
	output cwp_pkg::cmd_t head
);
	import cwp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/cwp_back.sv @@
// Back end: anchor/pending points, shared-multiplier straightness test, result register.
`default_nettype none
module cwp_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input cwp_pkg::cmd_t q_head,
	output logic q_pop,
	input logic [cwp_pkg::MIN_SEG_W-1:0] min_seg_len_sq,
	input logic [cwp_pkg::COS_W-1:0] cos_threshold,
	output logic out_valid,
	input logic out_stall,
	output cwp_pkg::out_item_t out_data
);
	import cwp_pkg::*;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int LEN_W = 2 * COORD_BITS + 2;
	localparam int HALF_W = LEN_W / 2;
	localparam int CSQ_W = 2 * COS_W;
	localparam int PLL_W = 2 * LEN_W;
	localparam int RHS_W = PLL_W + CSQ_W;
	localparam int MUL_W = (COORD_BITS + 2 > CSQ_W + 1) ? COORD_BITS + 2 : CSQ_W + 1;
	localparam int SH_AMT_W = $clog2(3 * HALF_W + 1);
	localparam int STEP_W = 5;
	localparam int STEP_LAST = 22;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_EMIT_PEND = 2'd2;
	localparam logic [1:0] ST_EMIT_NEW = 2'd3;

	localparam logic [2:0] DST_NONE = 3'd0;
	localparam logic [2:0] DST_L1 = 3'd1;
	localparam logic [2:0] DST_L2 = 3'd2;
	localparam logic [2:0] DST_DOT = 3'd3;
	localparam logic [2:0] DST_CSQ = 3'd4;
	localparam logic [2:0] DST_PLL = 3'd5;
	localparam logic [2:0] DST_LHS = 3'd6;
	localparam logic [2:0] DST_RHS = 3'd7;

	localparam logic [2:0] SH_0 = 3'd0;
	localparam logic [2:0] SH_H = 3'd1;
	localparam logic [2:0] SH_H1 = 3'd2;
	localparam logic [2:0] SH_2H = 3'd3;
	localparam logic [2:0] SH_3H = 3'd4;

	typedef logic signed [DIFF_W-1:0] diff_t;

	logic [1:0] state_q;
	logic [STEP_W-1:0] step_q;
	logic out_valid_q;
	out_item_t out_data_q;

	cmd_t cur_q;
	point_t anchor_q;
	point_t pending_q;
	diff_t da_q [3];
	diff_t db_q [3];

	logic [LEN_W-1:0] l1_q;
	logic [LEN_W-1:0] l2_q;
	logic signed [LEN_W:0] dot_q;
	logic [CSQ_W-1:0] csq_q;
	logic [PLL_W-1:0] pll_q;
	logic [PLL_W-1:0] lhs_q;
	logic [RHS_W-1:0] rhs_q;

	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [2*MUL_W-1:0] prod_s1;
	logic [2:0] dst;
	logic [2:0] sh;
	logic [2:0] dst_s1;
	logic [2:0] sh_s1;
	logic [SH_AMT_W-1:0] sh_amt;

	logic out_free;
	logic emit;
	logic start;
	logic last_step;
	logic seg_short;
	logic keep;

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign out_free = ~out_valid_q | ~out_stall;
	assign emit = ((state_q == ST_EMIT_PEND) || (state_q == ST_EMIT_NEW)) && out_free;
	assign q_pop = (state_q == ST_IDLE) & ~q_empty;
	assign start = q_pop & (q_head.op == CMD_TEST);
	assign last_step = (state_q == ST_CALC) & (step_q == STEP_W'(STEP_LAST));

	// keep if a segment is short, the turn goes backwards, or
	// dot^2 * 2^30 < c^2 * L1 * L2
	assign seg_short = (l1_q <= LEN_W'(min_seg_len_sq)) || (l2_q <= LEN_W'(min_seg_len_sq));
	assign keep = seg_short || dot_q[LEN_W] || ((RHS_W'(lhs_q) << CSQ_W) < rhs_q);

	// one partial product per step; L1*L2 is ready before the c^2 products need it
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		dst = DST_NONE;
		sh = SH_0;
		if (state_q == ST_CALC) begin
			case (step_q)
				5'd0: begin mul_a = MUL_W'(da_q[0]); mul_b = MUL_W'(da_q[0]); dst = DST_L1; end
				5'd1: begin mul_a = MUL_W'(db_q[0]); mul_b = MUL_W'(db_q[0]); dst = DST_L2; end
				5'd2: begin mul_a = MUL_W'(da_q[0]); mul_b = MUL_W'(db_q[0]); dst = DST_DOT; end
				5'd3: begin mul_a = MUL_W'(da_q[1]); mul_b = MUL_W'(da_q[1]); dst = DST_L1; end
				5'd4: begin mul_a = MUL_W'(db_q[1]); mul_b = MUL_W'(db_q[1]); dst = DST_L2; end
				5'd5: begin mul_a = MUL_W'(da_q[1]); mul_b = MUL_W'(db_q[1]); dst = DST_DOT; end
				5'd6: begin mul_a = MUL_W'(da_q[2]); mul_b = MUL_W'(da_q[2]); dst = DST_L1; end
				5'd7: begin mul_a = MUL_W'(db_q[2]); mul_b = MUL_W'(db_q[2]); dst = DST_L2; end
				5'd8: begin mul_a = MUL_W'(da_q[2]); mul_b = MUL_W'(db_q[2]); dst = DST_DOT; end
				5'd9: begin
					mul_a = MUL_W'(cos_threshold);
					mul_b = MUL_W'(cos_threshold);
					dst = DST_CSQ;
				end
				5'd10: begin
					mul_a = MUL_W'(l1_q[HALF_W-1:0]);
					mul_b = MUL_W'(l2_q[HALF_W-1:0]);
					dst = DST_PLL;
				end
				5'd11: begin
					mul_a = MUL_W'(l1_q[HALF_W-1:0]);
					mul_b = MUL_W'(l2_q[LEN_W-1:HALF_W]);
					dst = DST_PLL;
					sh = SH_H;
				end
				5'd12: begin
					mul_a = MUL_W'(l1_q[LEN_W-1:HALF_W]);
					mul_b = MUL_W'(l2_q[HALF_W-1:0]);
					dst = DST_PLL;
					sh = SH_H;
				end
				5'd13: begin
					mul_a = MUL_W'(l1_q[LEN_W-1:HALF_W]);
					mul_b = MUL_W'(l2_q[LEN_W-1:HALF_W]);
					dst = DST_PLL;
					sh = SH_2H;
				end
				5'd14: begin
					mul_a = MUL_W'(dot_q[HALF_W-1:0]);
					mul_b = MUL_W'(dot_q[HALF_W-1:0]);
					dst = DST_LHS;
				end
				5'd15: begin
					// cross term counted twice by the extra shift
					mul_a = MUL_W'(dot_q[LEN_W-1:HALF_W]);
					mul_b = MUL_W'(dot_q[HALF_W-1:0]);
					dst = DST_LHS;
					sh = SH_H1;
				end
				5'd16: begin
					mul_a = MUL_W'(dot_q[LEN_W-1:HALF_W]);
					mul_b = MUL_W'(dot_q[LEN_W-1:HALF_W]);
					dst = DST_LHS;
					sh = SH_2H;
				end
				5'd17: begin
					mul_a = MUL_W'(pll_q[0*HALF_W +: HALF_W]);
					mul_b = MUL_W'(csq_q);
					dst = DST_RHS;
				end
				5'd18: begin
					mul_a = MUL_W'(pll_q[1*HALF_W +: HALF_W]);
					mul_b = MUL_W'(csq_q);
					dst = DST_RHS;
					sh = SH_H;
				end
				5'd19: begin
					mul_a = MUL_W'(pll_q[2*HALF_W +: HALF_W]);
					mul_b = MUL_W'(csq_q);
					dst = DST_RHS;
					sh = SH_2H;
				end
				5'd20: begin
					mul_a = MUL_W'(pll_q[3*HALF_W +: HALF_W]);
					mul_b = MUL_W'(csq_q);
					dst = DST_RHS;
					sh = SH_3H;
				end
				default: begin
					dst = DST_NONE;
				end
			endcase
		end
	end

	always_comb begin
		unique case (sh_s1)
			SH_H: sh_amt = SH_AMT_W'(HALF_W);
			SH_H1: sh_amt = SH_AMT_W'(HALF_W + 1);
			SH_2H: sh_amt = SH_AMT_W'(2 * HALF_W);
			SH_3H: sh_amt = SH_AMT_W'(3 * HALF_W);
			default: sh_amt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
			dst_s1 <= DST_NONE;
			sh_s1 <= SH_0;
		end else begin
			dst_s1 <= dst;
			sh_s1 <= sh;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_head.op) inside
							CMD_FIRST, CMD_EMIT: state_q <= ST_EMIT_NEW;
							CMD_PEND: state_q <= ST_IDLE;
							CMD_TEST: begin
								state_q <= ST_CALC;
								step_q <= '0;
							end
						endcase
					end
				end
				ST_CALC: begin
					if (last_step) begin
						if (keep) begin
							state_q <= ST_EMIT_PEND;
						end else begin
							state_q <= cur_q.fin ? ST_EMIT_NEW : ST_IDLE;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_EMIT_PEND: begin
					if (out_free) begin
						state_q <= cur_q.fin ? ST_EMIT_NEW : ST_IDLE;
					end
				end
				ST_EMIT_NEW: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;

		if (q_pop) begin
			cur_q <= q_head;
		end
		if (q_pop && q_head.op == CMD_FIRST && !q_head.fin) begin
			anchor_q <= q_head.pt;
		end
		if (q_pop && q_head.op == CMD_PEND) begin
			pending_q <= q_head.pt;
		end
		if (start) begin
			da_q[0] <= DIFF_W'($signed(pending_q.x)) - DIFF_W'($signed(anchor_q.x));
			da_q[1] <= DIFF_W'($signed(pending_q.y)) - DIFF_W'($signed(anchor_q.y));
			da_q[2] <= DIFF_W'($signed(pending_q.z)) - DIFF_W'($signed(anchor_q.z));
			db_q[0] <= DIFF_W'($signed(q_head.pt.x)) - DIFF_W'($signed(pending_q.x));
			db_q[1] <= DIFF_W'($signed(q_head.pt.y)) - DIFF_W'($signed(pending_q.y));
			db_q[2] <= DIFF_W'($signed(q_head.pt.z)) - DIFF_W'($signed(pending_q.z));
		end

		if (start) begin
			l1_q <= '0;
			l2_q <= '0;
			dot_q <= '0;
			pll_q <= '0;
			lhs_q <= '0;
			rhs_q <= '0;
		end else begin
			case (dst_s1)
				DST_L1: l1_q <= l1_q + prod_s1[LEN_W-1:0];
				DST_L2: l2_q <= l2_q + prod_s1[LEN_W-1:0];
				DST_DOT: dot_q <= dot_q + $signed(prod_s1[LEN_W:0]);
				DST_CSQ: csq_q <= prod_s1[CSQ_W-1:0];
				DST_PLL: pll_q <= pll_q + (PLL_W'(prod_s1[2*HALF_W-1:0]) << sh_amt);
				DST_LHS: lhs_q <= lhs_q + (PLL_W'(prod_s1[2*HALF_W-1:0]) << sh_amt);
				DST_RHS: rhs_q <= rhs_q + (RHS_W'(prod_s1[HALF_W+CSQ_W-1:0]) << sh_amt);
				default: ;
			endcase
		end

		if (last_step && !keep) begin
			pending_q <= cur_q.pt;
		end
		if (state_q == ST_EMIT_PEND && out_free) begin
			out_data_q.out_x <= pending_q.x;
			out_data_q.out_y <= pending_q.y;
			out_data_q.out_z <= pending_q.z;
			out_data_q.out_final <= 1'b0;
			anchor_q <= pending_q;
			pending_q <= cur_q.pt;
		end
		if (state_q == ST_EMIT_NEW && out_free) begin
			out_data_q.out_x <= cur_q.pt.x;
			out_data_q.out_y <= cur_q.pt.y;
			out_data_q.out_z <= cur_q.pt.z;
			out_data_q.out_final <= cur_q.fin;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/collinear_waypoint_pruner.sv @@
// Top level of the collinear waypoint pruner.
// Waypoints enter one request at a time on the in channel and kept waypoints leave
// on the out channel; the first and final point of every path always pass, and a
// middle point is dropped when both of its segments are longer than min_seg_len_sq
// and the turn cosine is at least cos_threshold (exact integer test). A front end
// classifies each request and hands it to a four-entry queue, so input keeps flowing
// while the back end works, until the queue is full. The back end pops a start or a
// lone final point and then emits it, and pops a second point and holds it pending;
// a point that triggers the straightness test is popped, runs 23 calculation steps
// (21 partial products stepped one per cycle through the single shared 31x31
// multiplier plus pipeline drain and compare) and then emits any results. At most
// one result is produced per back-end cycle, two results per request at most. Write
// configuration only while the block is idle.
`default_nettype none
module collinear_waypoint_pruner (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input cwp_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output cwp_pkg::out_item_t out_data,
	input logic cfg_wr_en,
	input logic [cwp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [cwp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import cwp_pkg::*;

	logic [MIN_SEG_W-1:0] min_seg_len_sq_q;
	logic [COS_W-1:0] cos_threshold_q;

	logic q_full;
	logic q_empty;
	logic push;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_seg_len_sq_q <= MIN_SEG_RESET;
			cos_threshold_q <= COS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MIN_SEG_LEN_SQ: min_seg_len_sq_q <= cfg_wdata[MIN_SEG_W-1:0];
				REG_COS_THRESHOLD: cos_threshold_q <= cfg_wdata[COS_W-1:0];
				default: ;
			endcase
		end
	end

	cwp_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data (in_data),
		.q_full (q_full),
		.push (push),
		.push_cmd (push_cmd)
	);

	cwp_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push (push),
		.push_cmd (push_cmd),
		.full (q_full),
		.pop (q_pop),
		.empty (q_empty),
		.head (q_head)
	);

	cwp_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.q_empty (q_empty),
		.q_head (q_head),
		.q_pop (q_pop),
		.min_seg_len_sq (min_seg_len_sq_q),
		.cos_threshold (cos_threshold_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data (out_data)
	);
endmodule
`default_nettype wire

@@ rtl/core/cwp_checker.sv @@
// Port-level checker for the waypoint pruner, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module cwp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input cwp_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_stall,
	input cwp_pkg::out_item_t out_data
);
	import cwp_pkg::*;

	localparam int BAL_W = $clog2(QUEUE_DEPTH + 3);

	// paths whose final request is taken but whose final result is not yet delivered
	logic [BAL_W-1:0] fin_bal_q;
	logic fin_in;
	logic fin_out;
	logic out_held;

	assign fin_in = in_valid & ~in_stall & in_data.is_final;
	assign fin_out = out_valid & ~out_stall & out_data.out_final;
	assign out_held = out_valid & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_bal_q <= '0;
		end else begin
			fin_bal_q <= fin_bal_q + BAL_W'(fin_in) - BAL_W'(fin_out);
		end
	end

	`CWP_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "stalled out changed")
	`CWP_ASSERT(a_fin_src, out_valid && out_data.out_final |-> fin_bal_q != '0, "orphan final")
	`CWP_ASSERT(a_final_bound, fin_bal_q <= BAL_W'(QUEUE_DEPTH + 2), "too many open paths")
endmodule

bind collinear_waypoint_pruner cwp_checker u_cwp_checker (.*);
`default_nettype wire
